>>> design/hkm_pkg.sv
// Shared types and constants for the hashed key match table.
package hkm_pkg;

	localparam int KEY_W   = 168;
	localparam int HASH_W  = 32;
	localparam int BC_W    = 9;
	localparam int CNT_W   = 32;
	localparam int STAT_W  = 3;
	localparam int IDX_W   = 8;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int REG_IDX_W = 2;
	localparam int STEP_W  = 5;

	localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT    = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TARGET_MATCHES  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_STOP_AFTER_FIRST = 2'd2;

	localparam logic [STAT_W-1:0] ST_MISS       = 3'd0;
	localparam logic [STAT_W-1:0] ST_MATCH      = 3'd1;
	localparam logic [STAT_W-1:0] ST_STOP_FIRST = 3'd2;
	localparam logic [STAT_W-1:0] ST_TARGET     = 3'd3;
	localparam logic [STAT_W-1:0] ST_STORED     = 3'd4;
	localparam logic [STAT_W-1:0] ST_FULL       = 3'd5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic              start;
		logic [HASH_W-1:0] dividend;
		logic [BC_W-1:0]   divisor;
	} mod_req_t;

	typedef struct packed {
		logic            done;
		logic [BC_W-1:0] rem;
	} mod_rsp_t;

endpackage

>>> design/hkm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hkm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/hkm_mod.sv
// Bit-serial remainder unit: 32-bit dividend modulo a 9-bit divisor, one bit per cycle.
module hkm_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  hkm_pkg::mod_req_t req,
	output hkm_pkg::mod_rsp_t rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [hkm_pkg::STEP_W-1:0]   step_q;
	logic [hkm_pkg::HASH_W-1:0]   sh_q;
	logic [hkm_pkg::BC_W-1:0]     rem_q;
	logic [hkm_pkg::BC_W-1:0]     div_q;
	logic [hkm_pkg::BC_W:0]       trial;
	logic [hkm_pkg::BC_W:0]       trial_sub;

	// shift next dividend bit into the partial remainder, subtract when it fits
	assign trial     = {rem_q, sh_q[hkm_pkg::HASH_W-1]};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			sh_q <= {sh_q[hkm_pkg::HASH_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial_sub[hkm_pkg::BC_W-1:0];
			end else begin
				rem_q <= trial[hkm_pkg::BC_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

>>> design/hashed_key_match_table.sv
// One request at a time: in_ready is high only in idle, so a new request waits until the last result is loaded.
// A request runs through the serial remainder unit, then a fill read and check; a lookup then scans entries.
// The entry scan reads one RAM entry and compares it with the key per step, until a hit or the bucket's fill.
// After reset the bucket fill memory is cleared by a sweep over all buckets before the first request.
// Registers reset to bucket_count 1, target_matches 0, stop_after_first 0; match count to 0.
// Key storage is not cleared; only entries below a bucket's fill are ever read.
module hashed_key_match_table #(
	parameter int NUM_BUCKETS  = 256,
	parameter int BUCKET_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hkm_pkg::ADDR_W-1:0]    paddr,
	input  logic [hkm_pkg::DATA_W-1:0]    pwdata,
	output logic [hkm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [63:0]                   key_low,
	input  logic [63:0]                   key_mid,
	input  logic [39:0]                   key_high,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hkm_pkg::STAT_W-1:0]    status,
	output logic [hkm_pkg::IDX_W-1:0]     bucket_index,
	output logic [hkm_pkg::CNT_W-1:0]     match_total
);

	localparam int BKT_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int ENTRIES = NUM_BUCKETS * BUCKET_DEPTH;
	localparam int EA_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W  = $clog2(BUCKET_DEPTH + 1);
	localparam int NCAP    = (NUM_BUCKETS > 511) ? 511 : NUM_BUCKETS;
	localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(BUCKET_DEPTH);
	localparam logic [BKT_W-1:0]  LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_FRD  = 3'd3;
	localparam logic [2:0] S_FCHK = 3'd4;
	localparam logic [2:0] S_ERD  = 3'd5;
	localparam logic [2:0] S_ECMP = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]                    state_q;
	logic [BKT_W-1:0]              clr_q;
	logic [hkm_pkg::BC_W-1:0]      bucket_count_q;
	logic [hkm_pkg::CNT_W-1:0]     target_q;
	logic                          stop_first_q;
	logic [hkm_pkg::CNT_W-1:0]     cnt_q;
	logic                          op_q;
	logic [hkm_pkg::KEY_W-1:0]     key_q;
	logic [BKT_W-1:0]              bkt_q;
	logic [FILL_W-1:0]             fill_q;
	logic [FILL_W-1:0]             k_q;
	logic [hkm_pkg::STAT_W-1:0]    st_q;
	logic                          out_valid_q;
	logic [hkm_pkg::STAT_W-1:0]    status_q;
	logic [hkm_pkg::IDX_W-1:0]     bucket_index_q;
	logic [hkm_pkg::CNT_W-1:0]     match_total_q;

	logic                          cfg_wr;
	logic [hkm_pkg::REG_IDX_W-1:0] reg_idx;
	logic [hkm_pkg::KEY_W-1:0]     key_in;
	logic [hkm_pkg::HASH_W-1:0]    hash;
	logic [hkm_pkg::BC_W-1:0]      n_eff;
	logic                          in_acc;
	logic                          out_load;
	hkm_pkg::mod_req_t             mod_req;
	hkm_pkg::mod_rsp_t             mod_rsp;

	logic                          fill_we;
	logic [BKT_W-1:0]              fill_waddr;
	logic [FILL_W-1:0]             fill_wdata;
	logic [FILL_W-1:0]             fill_rdata;
	logic [FILL_W-1:0]             fill_c;
	logic                          ent_we;
	logic                          ent_re;
	logic [EA_W-1:0]               ent_base;
	logic [EA_W-1:0]               ent_waddr;
	logic [EA_W-1:0]               ent_raddr;
	logic [hkm_pkg::KEY_W-1:0]     ent_rdata;
	logic                          hit;
	logic [hkm_pkg::CNT_W-1:0]     cnt_inc;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[hkm_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= hkm_pkg::BC_W'(1);
			target_q       <= '0;
			stop_first_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				hkm_pkg::REG_BUCKET_COUNT:     bucket_count_q <= pwdata[hkm_pkg::BC_W-1:0];
				hkm_pkg::REG_TARGET_MATCHES:   target_q       <= pwdata;
				hkm_pkg::REG_STOP_AFTER_FIRST: stop_first_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			hkm_pkg::REG_BUCKET_COUNT:     prdata = hkm_pkg::DATA_W'(bucket_count_q);
			hkm_pkg::REG_TARGET_MATCHES:   prdata = target_q;
			hkm_pkg::REG_STOP_AFTER_FIRST: prdata = hkm_pkg::DATA_W'(stop_first_q);
			default:                       prdata = '0;
		endcase
	end

	// hash: XOR of the little-endian words at key bytes 1, 5, 9, 13, 17
	assign key_in = {key_high, key_mid, key_low};
	assign hash   = key_in[8 +: 32] ^ key_in[40 +: 32] ^ key_in[72 +: 32]
	              ^ key_in[104 +: 32] ^ key_in[136 +: 32];

	always_comb begin
		if (bucket_count_q == '0) begin
			n_eff = hkm_pkg::BC_W'(1);
		end else if (bucket_count_q > hkm_pkg::BC_W'(NCAP)) begin
			n_eff = hkm_pkg::BC_W'(NCAP);
		end else begin
			n_eff = bucket_count_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;

	assign mod_req.start    = in_acc;
	assign mod_req.dividend = hash;
	assign mod_req.divisor  = n_eff;

	hkm_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	// bucket fill memory, cleared by a sweep after reset
	assign fill_c     = (fill_rdata > DEPTH_F) ? DEPTH_F : fill_rdata;
	assign fill_we    = (state_q == S_CLR) ||
	                    (state_q == S_FCHK && op_q == hkm_pkg::OP_INSERT && fill_c < DEPTH_F);
	assign fill_waddr = (state_q == S_CLR) ? clr_q : bkt_q;
	assign fill_wdata = (state_q == S_CLR) ? '0 : fill_c + 1'b1;

	hkm_ram #(
		.WIDTH (FILL_W),
		.DEPTH (NUM_BUCKETS)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (fill_waddr),
		.wdata (fill_wdata),
		.re    (state_q == S_FRD),
		.raddr (bkt_q),
		.rdata (fill_rdata)
	);

	// key entry memory, BUCKET_DEPTH slots per bucket
	assign ent_base  = EA_W'(bkt_q) * EA_W'(BUCKET_DEPTH);
	assign ent_waddr = ent_base + EA_W'(fill_c);
	assign ent_raddr = ent_base + EA_W'(k_q);
	assign ent_we    = (state_q == S_FCHK) && (op_q == hkm_pkg::OP_INSERT) && (fill_c < DEPTH_F);
	assign ent_re    = (state_q == S_ERD);

	hkm_ram #(
		.WIDTH (hkm_pkg::KEY_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (key_q),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign hit     = (ent_rdata == key_q);
	assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_BKT) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_rsp.done) begin
						state_q <= S_FRD;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (op_q == hkm_pkg::OP_INSERT || fill_c == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_ERD: state_q <= S_ECMP;
				S_ECMP: begin
					if (hit) begin
						cnt_q   <= cnt_inc;
						state_q <= S_OUT;
					end else if (k_q + 1'b1 == fill_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_ERD;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= operation;
			key_q <= key_in;
		end
		if (state_q == S_HASH && mod_rsp.done) begin
			bkt_q <= BKT_W'(mod_rsp.rem);
		end
		if (state_q == S_FCHK) begin
			fill_q <= fill_c;
			k_q    <= '0;
			if (op_q == hkm_pkg::OP_INSERT) begin
				st_q <= (fill_c < DEPTH_F) ? hkm_pkg::ST_STORED : hkm_pkg::ST_FULL;
			end else begin
				st_q <= hkm_pkg::ST_MISS;
			end
		end
		if (state_q == S_ECMP) begin
			k_q <= k_q + 1'b1;
			if (hit) begin
				if (target_q != '0 && cnt_inc >= target_q) begin
					st_q <= hkm_pkg::ST_TARGET;
				end else if (stop_first_q) begin
					st_q <= hkm_pkg::ST_STOP_FIRST;
				end else begin
					st_q <= hkm_pkg::ST_MATCH;
				end
			end
		end
		if (out_load) begin
			status_q       <= st_q;
			bucket_index_q <= hkm_pkg::IDX_W'(bkt_q);
			match_total_q  <= cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign bucket_index = bucket_index_q;
	assign match_total  = match_total_q;

endmodule

>>> design/hkm_checker.sv
// Port-level checks for the hashed key match table, bound to the top level.
module hkm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [hkm_pkg::STAT_W-1:0] status,
	input logic [hkm_pkg::IDX_W-1:0]  bucket_index,
	input logic [hkm_pkg::CNT_W-1:0]  match_total
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(bucket_index) && $stable(match_total))
		else $error("result changed while stalled");

	// one request at a time: ready drops right after a request is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= hkm_pkg::ST_FULL)
		else $error("undefined status code");

	// a match always has counted at least one hit
	a_match_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == hkm_pkg::ST_MATCH || status == hkm_pkg::ST_STOP_FIRST ||
		status == hkm_pkg::ST_TARGET) |-> match_total != '0)
		else $error("match reported with zero total");

endmodule

bind hashed_key_match_table hkm_checker u_hkm_checker (.*);
